/* src/word_line_concordance_table_assert.svh */
`ifndef WORD_LINE_CONCORDANCE_TABLE_ASSERT_SVH
`define WORD_LINE_CONCORDANCE_TABLE_ASSERT_SVH
// implication check under reset
`define WLCT_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication check under reset
`define WLCT_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

/* src/wlct_pkg.sv */
package wlct_pkg;
   localparam int MAX_ENTRIES = 512;
   localparam int MAX_LINES   = 64;
   localparam int MAX_WORD    = 64;
   localparam int EW = $clog2(MAX_ENTRIES);
   localparam int LW = $clog2(MAX_LINES);
   localparam int WW = $clog2(MAX_WORD);
   localparam int CW = $clog2(MAX_LINES + 1);
   localparam int LENW = $clog2(MAX_WORD + 1);
   localparam int UW = $clog2(MAX_ENTRIES + 1);
   localparam logic [15:0] LINE_MAX = 16'hFFFF;
   localparam logic [7:0] CHAR_NL = 8'h0A;
   localparam int QDEPTH = 2;

   typedef enum logic {FUNC_TEXT = 1'b0, FUNC_READ = 1'b1} func_type;

   typedef struct packed {
      func_type    func;
      logic [EW-1:0] entry_sel;
      logic [LW-1:0] slot_sel;
      logic [15:0] line;
      logic [LENW-1:0] length;
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic [8:0]  entry_index;
      logic        is_new;
      logic        line_stored;
      logic        table_full;
      logic [15:0] line_number;
      logic [6:0]  line_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_CNT, ST_RD_LINE, ST_RD_DONE,
      ST_SRCH_LEN, ST_SRCH_CMP, ST_SRCH_NEXT, ST_APPEND,
      ST_NEW_COPY, ST_NEW_DONE, ST_OUT
   } state_type;

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction
endpackage

/* src/wlct_front.sv */
module wlct_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_func,
   input  logic [7:0] in_char,
   input  logic [8:0] in_entry,
   input  logic [5:0] in_slot,
   output logic cmd_valid,
   input  logic cmd_ready,
   output wlct_pkg::cmd_type cmd,
   output logic [7:0] word_char,
   input  logic [wlct_pkg::WW-1:0] word_addr,
   input  logic word_done
);
   import wlct_pkg::*;
   logic [7:0] word_mem [MAX_WORD];
   logic [LENW-1:0] len_ff, len_in;
   logic [15:0] line_ff, line_in;
   logic [7:0] word_char_ff;
   logic take, letter, emit;
   // word buffer is held while a word command is in flight: stall input until its result leaves
   logic busy_ff, busy_in;

   assign letter = is_letter(in_char);
   assign in_ready = !busy_ff && (cmd_ready || (in_func == FUNC_TEXT && (letter || len_ff == '0)));
   assign take = in_valid && in_ready;
   assign emit = take && (in_func == FUNC_READ || (!letter && len_ff != '0));
   assign cmd_valid = emit;
   assign cmd.func = func_type'(in_func);
   assign cmd.entry_sel = in_entry[EW-1:0];
   assign cmd.slot_sel = in_slot[LW-1:0];
   assign cmd.line = line_ff;
   assign cmd.length = len_ff;
   assign word_char = word_char_ff;

   always_comb begin
      len_in = len_ff;
      line_in = line_ff;
      busy_in = busy_ff;
      if (take && in_func == FUNC_TEXT) begin
         if (letter) begin
            if (len_ff < LENW'(MAX_WORD)) len_in = len_ff + 1'b1;
         end else begin
            len_in = '0;
            if (len_ff != '0) busy_in = 1'b1;
            if (in_char == CHAR_NL && line_ff != LINE_MAX) line_in = line_ff + 1'b1;
         end
      end
      if (word_done && busy_ff) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take && in_func == FUNC_TEXT && letter && len_ff < LENW'(MAX_WORD))
         word_mem[len_ff[WW-1:0]] <= in_char;
      word_char_ff <= word_mem[word_addr];
      if (reset) begin
         len_ff <= '0;
         line_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         line_ff <= line_in;
         busy_ff <= busy_in;
      end
   end
endmodule

/* src/wlct_queue.sv */
module wlct_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  wlct_pkg::cmd_type in_cmd,
   output logic out_valid,
   input  logic out_ready,
   output wlct_pkg::cmd_type out_cmd
);
   import wlct_pkg::*;
   cmd_type q_ff [QDEPTH];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;
   assign in_ready = cnt_ff != 2'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_cmd = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_cmd;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

/* src/wlct_back.sv */
module wlct_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_ready,
   input  wlct_pkg::cmd_type cmd,
   output logic [wlct_pkg::WW-1:0] word_addr,
   input  logic [7:0] word_char,
   output logic word_done,
   output logic out_valid,
   input  logic out_ready,
   output wlct_pkg::rsp_type rsp
);
   import wlct_pkg::*;
   localparam int CA = EW + WW;
   localparam int LA = EW + LW;
   logic [7:0]  chars_mem [MAX_ENTRIES*MAX_WORD];
   logic [15:0] lines_mem [MAX_ENTRIES*MAX_LINES];
   logic [LENW-1:0] len_mem [MAX_ENTRIES];
   logic [CW-1:0] cnt_mem [MAX_ENTRIES];

   state_type st_ff, st_in;
   cmd_type c_ff, c_in;
   logic [UW-1:0] used_ff, used_in;
   logic [EW-1:0] e_ff, e_in;
   logic [WW:0] k_ff, k_in;
   logic [WW-1:0] wa_ff, wa_in;
   logic match_ff, match_in;
   rsp_type r_ff, r_in;
   logic [7:0] ch_rd;
   logic [15:0] ln_rd;
   logic [LENW-1:0] len_rd;
   logic [CW-1:0] cnt_rd;
   logic [CA-1:0] ch_addr;
   logic ch_we, ln_we, len_we, cnt_we;
   logic [CA-1:0] chw_addr;
   logic [LA-1:0] ln_addr;
   logic [15:0] ln_wd;
   logic [CW-1:0] cnt_wd;

   assign word_addr = wa_ff;
   assign out_valid = st_ff == ST_OUT;
   assign rsp = r_ff;
   assign cmd_ready = st_ff == ST_IDLE;
   assign word_done = out_valid && out_ready && !r_ff.kind;

   always_comb begin
      st_in = st_ff; c_in = c_ff; used_in = used_ff; e_in = e_ff; k_in = k_ff;
      wa_in = wa_ff; match_in = match_ff; r_in = r_ff;
      ch_we = 1'b0; ln_we = 1'b0; len_we = 1'b0; cnt_we = 1'b0;
      ch_addr = {e_ff, k_ff[WW-1:0]};
      chw_addr = {e_ff, wa_ff};
      ln_addr = {e_ff, c_ff.slot_sel};
      ln_wd = c_ff.line; cnt_wd = cnt_rd;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               c_in = cmd; e_in = '0; k_in = '0; wa_in = '0;
               if (cmd.func == FUNC_READ) begin
                  e_in = cmd.entry_sel;
                  st_in = ST_RD_CNT;
               end else begin
                  st_in = ST_SRCH_LEN;
               end
            end
         end
         ST_RD_CNT: st_in = ST_RD_LINE;
         ST_RD_LINE: st_in = ST_RD_DONE;
         ST_RD_DONE: begin
            r_in = '0;
            r_in.kind = 1'b1;
            r_in.entry_index = 9'(c_ff.entry_sel);
            if (UW'(e_ff) < used_ff) begin
               r_in.line_count = 7'(cnt_rd);
               if (CW'(c_ff.slot_sel) < cnt_rd) r_in.line_number = ln_rd;
            end
            st_in = ST_OUT;
         end
         ST_SRCH_LEN: begin
            if (UW'(e_ff) >= used_ff) begin
               st_in = (used_ff >= UW'(MAX_ENTRIES)) ? ST_NEW_DONE : ST_NEW_COPY;
               k_in = '0; wa_in = '0;
            end else begin
               k_in = '0; wa_in = '0; match_in = 1'b1;
               st_in = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            // one char per cycle: char k-1 of both words is present at step k
            if (len_rd != c_ff.length) begin
               st_in = ST_SRCH_NEXT; match_in = 1'b0;
            end else begin
               if (k_ff != '0 && (k_ff - 1'b1) < (WW+1)'(c_ff.length) && ch_rd != word_char)
                  match_in = 1'b0;
               if (k_ff >= (WW+1)'(c_ff.length) + (WW+1)'(2))
                  st_in = ST_SRCH_NEXT;
               k_in = k_ff + 1'b1;
               wa_in = k_ff[WW-1:0] + 1'b1;
            end
         end
         ST_SRCH_NEXT: begin
            if (match_ff) begin
               st_in = ST_APPEND;
            end else begin
               e_in = e_ff + 1'b1;
               k_in = '0;
               if (e_ff == EW'(MAX_ENTRIES - 1)) begin
                  st_in = (used_ff >= UW'(MAX_ENTRIES)) ? ST_NEW_DONE : ST_NEW_COPY;
                  e_in = EW'(used_ff);
               end else begin
                  st_in = ST_SRCH_LEN;
               end
               wa_in = '0;
            end
         end
         ST_APPEND: begin
            r_in = '0;
            r_in.entry_index = 9'(e_ff);
            r_in.line_number = c_ff.line;
            r_in.line_count = 7'(cnt_rd);
            if (cnt_rd < CW'(MAX_LINES)) begin
               ln_we = 1'b1; ln_addr = {e_ff, cnt_rd[LW-1:0]};
               cnt_we = 1'b1; cnt_wd = cnt_rd + 1'b1;
               r_in.line_stored = 1'b1;
               r_in.line_count = 7'(cnt_rd + 1'b1);
            end
            st_in = ST_OUT;
         end
         ST_NEW_COPY: begin
            // word_char at step k holds char k-1
            k_in = k_ff + 1'b1;
            wa_in = k_ff[WW-1:0] + 1'b1;
            if (k_ff != '0) begin
               ch_we = 1'b1;
               chw_addr = {e_ff, WW'(k_ff - 1'b1)};
            end
            if (k_ff == (WW+1)'(MAX_WORD)) begin
               len_we = 1'b1; cnt_we = 1'b1; cnt_wd = CW'(1);
               ln_we = 1'b1; ln_addr = {e_ff, LW'(0)};
               used_in = used_ff + 1'b1;
               r_in = '0;
               r_in.entry_index = 9'(e_ff);
               r_in.is_new = 1'b1; r_in.line_stored = 1'b1;
               r_in.line_number = c_ff.line; r_in.line_count = 7'd1;
               st_in = ST_OUT;
            end
         end
         ST_NEW_DONE: begin
            r_in = '0;
            r_in.table_full = 1'b1;
            r_in.line_number = c_ff.line;
            st_in = ST_OUT;
         end
         ST_OUT: if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   logic [EW-1:0] e_rd;
   assign e_rd = (st_ff == ST_SRCH_NEXT) ? e_in : e_ff;

   always_ff @(posedge clock) begin
      ch_rd <= chars_mem[ch_addr];
      ln_rd <= lines_mem[{c_ff.entry_sel, c_ff.slot_sel}];
      if (ch_we) chars_mem[chw_addr] <= word_char;
      if (ln_we) lines_mem[ln_addr] <= ln_wd;
   end

   // metadata: per-entry arrays, valid only below used count
   always_ff @(posedge clock) begin
      len_rd <= len_mem[e_rd];
      cnt_rd <= cnt_mem[(st_ff == ST_IDLE) ? cmd.entry_sel : e_rd];
      if (len_we) len_mem[e_ff] <= c_ff.length;
      if (cnt_we) cnt_mem[e_ff] <= cnt_wd;
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in; e_ff <= e_in; k_ff <= k_in; r_ff <= r_in;
      match_ff <= match_in;
      if (reset) begin
         st_ff <= ST_IDLE; used_ff <= '0; wa_ff <= '0;
      end else begin
         st_ff <= st_in; used_ff <= used_in; wa_ff <= wa_in;
      end
   end
endmodule

/* src/word_line_concordance_table.sv */
// Word/line concordance table. Text bytes (func 0) build words. A word end
// searches the stored entries one at a time, checking the length first and then
// the characters; if no entry matches and the table has room, a new entry then
// copies the word. After a word end, input is held off until that word's
// transaction is accepted on the result side. Reads (func 1) pass through the
// queue and the back end's ST_RD_CNT, ST_RD_LINE and ST_RD_DONE states before
// their result is presented. The table walk in the back end sets the rate.
module word_line_concordance_table (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata, // char_code[7:0], entry_sel[16:8], slot_sel[22:17]
   input  logic req_tuser,        // func
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata, // entry_index, is_new, line_stored, table_full,
                                  // line_number, line_count
   output logic rsp_tuser         // kind
);
   import wlct_pkg::*;
   cmd_type fc, bc;
   logic fv, fr, bv, br;
   logic [7:0] wc;
   logic [WW-1:0] wa;
   logic wd;
   rsp_type r;
   wlct_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_func(req_tuser), .in_char(req_tdata[7:0]), .in_entry(req_tdata[16:8]),
      .in_slot(req_tdata[22:17]), .cmd_valid(fv), .cmd_ready(fr), .cmd(fc),
      .word_char(wc), .word_addr(wa), .word_done(wd));
   wlct_queue u_queue (.clock, .reset, .in_valid(fv), .in_ready(fr), .in_cmd(fc),
      .out_valid(bv), .out_ready(br), .out_cmd(bc));
   wlct_back u_back (.clock, .reset, .cmd_valid(bv), .cmd_ready(br), .cmd(bc),
      .word_addr(wa), .word_char(wc), .word_done(wd), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .rsp(r));
   assign rsp_tuser = r.kind;
   assign rsp_tdata = {5'd0, r.line_count, r.line_number, r.table_full,
                       r.line_stored, r.is_new, r.entry_index};
endmodule

/* src/wlct_checker.sv */
`include "word_line_concordance_table_assert.svh"
module wlct_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic rsp_tuser
);
   `WLCT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `WLCT_ASSERT_IMP(a_read_flags, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[11:9] == 3'b000)
   `WLCT_ASSERT_IMP(a_full_zero, clock, reset, rsp_tvalid && rsp_tdata[11], rsp_tdata[39:28] == '0)
   `WLCT_ASSERT_IMP(a_new_one, clock, reset, rsp_tvalid && rsp_tdata[9], rsp_tdata[34:28] == 7'd1)
endmodule
bind word_line_concordance_table wlct_checker u_chk (.*);

/* verif/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import wlct_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int N_ITEMS = 900;

   typedef struct {
      func_type   func;
      logic [7:0] ch;
      logic [8:0] esel;
      logic [5:0] ssel;
   } text_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic rsp_tuser;

   word_line_concordance_table u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   text_item_type pending_q[$];
   rsp_type    expected_q[$];
   int n_accepted = 0;
   int n_results = 0;
   int n_errors = 0;
   int send_idle_pct = 36;
   int recv_idle_pct = 78;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   // concordance shadow
   logic [7:0]  word_store[MAX_ENTRIES][MAX_WORD];
   int          word_len[MAX_ENTRIES];
   logic [15:0] line_store[MAX_ENTRIES][MAX_LINES];
   int          line_cnt[MAX_ENTRIES];
   int          n_entries = 0;
   logic [7:0]  cur_word[MAX_WORD];
   int          cur_len = 0;
   int          cur_line = 0;

   function automatic bit alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit word_hit(int e);
      if (word_len[e] != cur_len) return 0;
      for (int i = 0; i < cur_len; i++)
         if (word_store[e][i] != cur_word[i]) return 0;
      return 1;
   endfunction

   task automatic close_word();
      rsp_type r;
      int hit;
      r = '0;
      hit = -1;
      r.line_number = cur_line[15:0];
      for (int e = 0; e < n_entries; e++)
         if (hit < 0 && word_hit(e)) hit = e;
      if (hit >= 0) begin
         r.entry_index = hit[8:0];
         if (line_cnt[hit] < MAX_LINES) begin
            line_store[hit][line_cnt[hit]] = cur_line[15:0];
            line_cnt[hit]++;
            r.line_stored = 1'b1;
         end
         r.line_count = line_cnt[hit][6:0];
      end else if (n_entries >= MAX_ENTRIES) begin
         r.table_full = 1'b1;
      end else begin
         for (int i = 0; i < cur_len; i++) word_store[n_entries][i] = cur_word[i];
         word_len[n_entries] = cur_len;
         line_store[n_entries][0] = cur_line[15:0];
         line_cnt[n_entries] = 1;
         r.entry_index = n_entries[8:0];
         r.is_new = 1'b1;
         r.line_stored = 1'b1;
         r.line_count = 7'd1;
         n_entries++;
      end
      expected_q.push_back(r);
   endtask

   task automatic predict_item(text_item_type it);
      rsp_type r;
      r = '0;
      if (it.func == FUNC_READ) begin
         r.kind = 1'b1;
         r.entry_index = it.esel;
         if (it.esel < n_entries) begin
            r.line_count = line_cnt[it.esel][6:0];
            if (it.ssel < line_cnt[it.esel]) r.line_number = line_store[it.esel][it.ssel];
         end
         expected_q.push_back(r);
      end else if (alpha(it.ch)) begin
         if (cur_len < MAX_WORD) begin
            cur_word[cur_len] = it.ch;
            cur_len++;
         end
      end else begin
         if (cur_len > 0) close_word();
         cur_len = 0;
         if (it.ch == CHAR_NL && cur_line < 65535) cur_line++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      text_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            it.func = func_type'(req_tuser);
            it.ch = req_tdata[7:0];
            it.esel = req_tdata[16:8];
            it.ssel = req_tdata[22:17];
            predict_item(it);
            n_accepted++;
         end
         if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            it = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= it.func;
            req_tdata <= {1'b0, it.ssel, it.esel, it.ch};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.kind = rsp_tuser;
            got.entry_index = rsp_tdata[8:0];
            got.is_new = rsp_tdata[9];
            got.line_stored = rsp_tdata[10];
            got.table_full = rsp_tdata[11];
            got.line_number = rsp_tdata[27:12];
            got.line_count = rsp_tdata[34:28];
            n_results++;
            if (expected_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected transaction: %p", got);
            end else begin
               exp_r = expected_q.pop_front();
               if (got.kind != exp_r.kind || got.entry_index != exp_r.entry_index ||
                   got.is_new != exp_r.is_new || got.line_stored != exp_r.line_stored ||
                   got.table_full != exp_r.table_full ||
                   got.line_number != exp_r.line_number ||
                   got.line_count != exp_r.line_count || rsp_tdata[39:35] != '0) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("mismatch #%0d: expected %p actual %p", n_results, exp_r, got);
               end
            end
            if (n_results == 50) hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // idle mix follows progress
   always @(posedge clock) begin
      if (n_accepted < 300) begin
         send_idle_pct <= 36;
         recv_idle_pct <= 78;
      end else if (n_accepted < 600) begin
         send_idle_pct <= 78;
         recv_idle_pct <= 36;
      end else begin
         send_idle_pct <= 0;
         recv_idle_pct <= 0;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic push_char(logic [7:0] c);
      text_item_type it;
      it.func = FUNC_TEXT;
      it.ch = c;
      it.esel = 9'($urandom);
      it.ssel = 6'($urandom);
      pending_q.push_back(it);
   endtask

   task automatic push_read(int e, int s);
      text_item_type it;
      it.func = FUNC_READ;
      it.ch = 8'($urandom);
      it.esel = e[8:0];
      it.ssel = s[5:0];
      pending_q.push_back(it);
   endtask

   task automatic push_word(string w);
      for (int i = 0; i < w.len(); i++) push_char(w[i]);
   endtask

   function automatic logic [7:0] rand_letter();
      int k;
      k = $urandom_range(0, 51);
      return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
   endfunction

   function automatic logic [7:0] rand_separator();
      logic [7:0] c;
      do c = 8'($urandom); while (alpha(c));
      return c;
   endfunction

   initial begin
      string vocab[30];
      string w;
      int r;
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         word_len[e] = 0;
         line_cnt[e] = 0;
      end

      // directed: line zero, repeats, case, long word, empty separators, reads
      push_word("Ab cd Ab");
      push_char(8'h0A);
      push_word("ab  \t");
      w = "";
      for (int i = 0; i < 70; i++) begin
         if (i % 2 == 0) w = {w, "Z"};
         else w = {w, "y"};
      end
      push_word(w);
      push_char(8'h0A);
      push_word("Ab.");
      push_read(0, 0);
      push_read(0, 1);
      push_read(0, 63);
      push_read(511, 0);
      push_read(2, 0);

      for (int i = 0; i < 30; i++) begin
         vocab[i] = "";
         r = $urandom_range(1, 6);
         for (int j = 0; j < r; j++) vocab[i] = {vocab[i], string'(rand_letter())};
      end
      while (pending_q.size() < N_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            push_word(vocab[$urandom_range(0, 29)]);
            r = $urandom_range(0, 99);
            if (r < 30) push_char(8'h0A);
            else if (r < 80) push_char(" ");
            else push_char(rand_separator());
         end else if (r < 82) begin
            if ($urandom_range(0, 3) == 0) push_read($urandom_range(0, 511), $urandom_range(0, 63));
            else push_read($urandom_range(0, 40), $urandom_range(0, 70) % 64);
         end else begin
            push_char(8'($urandom));
         end
      end
      push_char(" ");

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_q.size() == 0);
      @(posedge clock);
      wait (!req_tvalid && expected_q.size() == 0);
      repeat (200) @(posedge clock);
      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/wlct_pkg.sv
src/wlct_front.sv
src/wlct_queue.sv
src/wlct_back.sv
src/word_line_concordance_table.sv
src/wlct_checker.sv
verif/tb_top.sv
